>>> rtl/core/dsr_pkg.sv
// Shared widths, reset values and register indexes for the status reporter.
package dsr_pkg;

    localparam int PIN_COUNT  = 5;
    localparam int CNT_W      = 4;
    localparam int TICK_W     = 8;
    localparam int FRAME_W    = 6;
    localparam int ID_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef logic [CNT_W-1:0]     count_t;
    typedef logic [TICK_W-1:0]    tick_t;
    typedef logic [FRAME_W-1:0]   frame_t;
    typedef logic [ID_W-1:0]      node_t;
    typedef logic [PIN_COUNT-1:0] pins_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_DEBOUNCE = 2'd0;
    localparam cfg_idx_t REG_REFRESH  = 2'd1;
    localparam cfg_idx_t REG_NODE_ID  = 2'd2;

    localparam count_t DEBOUNCE_RESET = 4'd3;
    localparam tick_t  REFRESH_RESET  = 8'd4;
    localparam node_t  NODE_ID_RESET  = 8'd2;
    localparam frame_t FRAME_RESET    = 6'h3F;
    localparam tick_t  TICK_SAT       = 8'hFF;

endpackage

>>> rtl/core/dsr_if.sv
// Request channels: pin samples in, status reports out.
interface dsr_sample_if;
    logic               valid;
    logic               ready;
    dsr_pkg::pins_t     pin_levels;
    logic               paired;
    logic               link_ready;

    modport source (output valid, pin_levels, paired, link_ready, input ready);
    modport sink   (input valid, pin_levels, paired, link_ready, output ready);
endinterface

interface dsr_report_if;
    logic               valid;
    logic               ready;
    dsr_pkg::node_t     sender_id;
    dsr_pkg::frame_t    status_frame;

    modport source (output valid, sender_id, status_frame, input ready);
    modport sink   (input valid, sender_id, status_frame, output ready);
endinterface

>>> rtl/core/debounced_input_status_reporter_core.sv
// A report is registered and appears in the cycle after the sample request that causes it.
// Throughput: one sample request per cycle unless a pending report is stalled; the
// report register frees itself in the same cycle the downstream side takes it.
// Reset (rst_n, asynchronous, active low): counters clear, the last frame
// becomes all ones, the tick age clears, registers take 3 / 4 / 2.
module debounced_input_status_reporter_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [dsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsr_pkg::CFG_DATA_W-1:0] cfg_data,
    dsr_sample_if.sink                sample,
    dsr_report_if.source              report
);
    import dsr_pkg::*;

    // configuration registers
    count_t debounce_reg;
    tick_t  refresh_reg;
    node_t  node_id_reg;

    // reporter state
    frame_t last_frame_reg;
    frame_t last_frame_next;
    tick_t  age_reg;
    tick_t  age_next;
    tick_t  age_aged;

    // report register
    logic   rpt_valid_reg;
    logic   rpt_valid_next;
    node_t  rpt_id_reg;
    frame_t rpt_frame_reg;

    logic   accept;
    logic   count_en;
    logic   send;
    pins_t  debounced;
    frame_t frame;

    // Take a new request whenever the report slot is empty or being drained.
    assign sample.ready = !rpt_valid_reg || report.ready;
    assign accept       = sample.valid && sample.ready;

    // Counters only move on paired ticks.
    assign count_en = accept && sample.paired;

    dsr_debounce u_debounce
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (count_en),
        .pin_levels (sample.pin_levels),
        .threshold  (debounce_reg),
        .debounced  (debounced)
    );

    // Bit 5 of the frame is always clear, so the reset value never matches.
    assign frame = {1'b0, debounced};

    always_comb
    begin
        // age first, saturating
        age_aged = (age_reg == TICK_SAT) ? age_reg : age_reg + tick_t'(1);

        send = sample.paired && sample.link_ready &&
               ((frame != last_frame_reg) || (age_aged >= refresh_reg));

        last_frame_next = last_frame_reg;
        age_next        = age_reg;
        if (accept)
        begin
            if (send)
            begin
                last_frame_next = frame;
                age_next        = '0;
            end
            else
            begin
                // unpaired, link not ready or nothing to say: keep aging, retry later
                age_next = age_aged;
            end
        end

        // drop the report once taken, load a new one on a sending tick
        if (accept)
            rpt_valid_next = send;
        else if (report.ready)
            rpt_valid_next = 1'b0;
        else
            rpt_valid_next = rpt_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            refresh_reg  <= REFRESH_RESET;
            node_id_reg  <= NODE_ID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data[CNT_W-1:0];
                REG_REFRESH:  refresh_reg  <= cfg_data[TICK_W-1:0];
                REG_NODE_ID:  node_id_reg  <= cfg_data[ID_W-1:0];
                default:      ; // unknown index: ignore the write
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_frame_reg <= FRAME_RESET;
            age_reg        <= '0;
            rpt_valid_reg  <= 1'b0;
        end
        else
        begin
            last_frame_reg <= last_frame_next;
            age_reg        <= age_next;
            rpt_valid_reg  <= rpt_valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept && send)
        begin
            rpt_id_reg    <= node_id_reg;
            rpt_frame_reg <= frame;
        end
    end

    assign report.valid        = rpt_valid_reg;
    assign report.sender_id    = rpt_id_reg;
    assign report.status_frame = rpt_frame_reg;

endmodule

>>> rtl/core/dsr_debounce.sv
// Bank of saturating hold counters, one per active-low pin.
module dsr_debounce
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  dsr_pkg::pins_t  pin_levels,
    input  dsr_pkg::count_t threshold,
    output dsr_pkg::pins_t  debounced
);
    import dsr_pkg::*;

    count_t cnt_reg  [PIN_COUNT];
    count_t cnt_next [PIN_COUNT];

    always_comb
    begin
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            if (!pin_levels[i])
            begin
                // advance while below threshold, then hold
                if (cnt_reg[i] < threshold)
                    cnt_next[i] = cnt_reg[i] + count_t'(1);
                else
                    cnt_next[i] = cnt_reg[i];
                debounced[i] = (cnt_next[i] >= threshold);
            end
            else
            begin
                cnt_next[i]  = '0;
                debounced[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIN_COUNT; i++)
                cnt_reg[i] <= '0;
        end
        else if (en)
        begin
            for (int i = 0; i < PIN_COUNT; i++)
                cnt_reg[i] <= cnt_next[i];
        end
    end

endmodule
